// ===== hdl/pta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants of the pixel tone adjuster
// Mode and register codes, configuration bundle, pipeline advance bundle and
// the fixed-point constants of the divide-by-100 stage.
// ----------------------------------------------------------------------------
package pta_pkg;

  typedef enum logic [1:0] {
    MODE_PASS     = 2'd0,
    MODE_BRIGHT   = 2'd1,
    MODE_CONTRAST = 2'd2,
    MODE_GAMMA    = 2'd3
  } pta_mode_t;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_BRIGHT    = 2'd1,
    REG_CONTRAST  = 2'd2,
    REG_HAS_ALPHA = 2'd3
  } pta_reg_t;

  typedef enum logic {
    OP_PIXEL     = 1'b0,
    OP_TABLE_WR  = 1'b1
  } pta_op_t;

  typedef struct packed {
    pta_mode_t          mode;
    logic signed [7:0]  bright;
    logic signed [10:0] contrast;
  } pta_cfg_t;

  // Load enables of the three lane stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pta_adv_t;

  localparam logic [7:0]  LEVEL_MAX    = 8'd255;
  localparam logic [12:0] MID_LEVEL    = 13'd127;
  localparam logic [10:0] PCT_FULL     = 11'd255;
  // floor(x/100) == (x*167773) >> 24 for every x below 199728.
  localparam logic [17:0] DIV100_RECIP = 18'd167773;
  localparam int          DIV100_SHIFT = 24;

endpackage
`default_nettype wire

// ===== hdl/pta_flow.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pta_flow: pipeline occupancy and handshake control
// Tracks the valid bit of each of the three lane stages and lets a stage
// load whenever it is empty or the stage ahead of it moves on.
// ----------------------------------------------------------------------------
module pta_flow (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              is_pixel,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output pta_pkg::pta_adv_t      adv
);
  import pta_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;

  always_comb begin
    adv.ld3 = !v3_r || out_tready;
    adv.ld2 = !v2_r || adv.ld3;
    adv.ld1 = !v1_r || adv.ld2;
    in_tready = adv.ld1;
    v1_nxt = adv.ld1 ? (in_tvalid && is_pixel) : v1_r;
    v2_nxt = adv.ld2 ? v1_r : v2_r;
    v3_nxt = adv.ld3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign out_tvalid = v3_r;

endmodule
`default_nettype wire

// ===== hdl/pta_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pta_lane: tone adjustment of one 8-bit component
// Stage 1 forms the signed product and reads this lane's copy of the gamma
// table, stage 2 divides the magnitude by 100, stage 3 adds, clamps, selects.
// ----------------------------------------------------------------------------
module pta_lane (
  input  wire logic              clk,
  input  wire pta_pkg::pta_cfg_t cfg,
  input  wire pta_pkg::pta_adv_t adv,
  input  wire logic              force_max,
  input  wire logic              tbl_wr_en,
  input  wire logic [7:0]        tbl_wr_addr,
  input  wire logic [7:0]        tbl_wr_data,
  input  wire logic [7:0]        pix_in,
  output logic [7:0]             pix_out
);
  import pta_pkg::*;

  logic [7:0] gamma_mem [256];

  logic signed [8:0]  op_a;
  logic signed [10:0] op_b;
  logic signed [19:0] prod;
  logic [19:0]        prod_abs;

  logic [17:0] s1_mag_r;
  logic        s1_neg_r;
  logic [7:0]  s1_pix_r;
  logic [7:0]  s1_gam_r;

  logic [35:0] recip_prod;
  logic [10:0] s2_q_r;
  logic        s2_neg_r;
  logic [7:0]  s2_pix_r;
  logic [7:0]  s2_gam_r;

  logic signed [12:0] q_signed;
  logic signed [12:0] base;
  logic signed [12:0] sum;
  logic [7:0]         clamped;
  logic [7:0]         pix_out_nxt;
  logic [7:0]         pix_out_r;

  // Brightness reuses the contrast path: (b*255)/100 is added to the pixel,
  // while contrast adds (v-127)*c/100 to the midpoint.
  always_comb begin
    if (cfg.mode == MODE_BRIGHT) begin
      op_a = {cfg.bright[7], cfg.bright};
      op_b = $signed(PCT_FULL);
    end else begin
      op_a = $signed({1'b0, pix_in}) - $signed(9'd127);
      op_b = cfg.contrast;
    end
    prod     = op_a * op_b;
    prod_abs = prod[19] ? 20'(-prod) : 20'(prod);
  end

  always_ff @(posedge clk) begin
    if (tbl_wr_en) begin
      gamma_mem[tbl_wr_addr] <= tbl_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      s1_gam_r <= gamma_mem[pix_in];
      s1_mag_r <= prod_abs[17:0];
      s1_neg_r <= prod[19];
      s1_pix_r <= pix_in;
    end
  end

  assign recip_prod = s1_mag_r * DIV100_RECIP;

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      s2_q_r   <= recip_prod[DIV100_SHIFT +: 11];
      s2_neg_r <= s1_neg_r;
      s2_pix_r <= s1_pix_r;
      s2_gam_r <= s1_gam_r;
    end
  end

  always_comb begin
    q_signed = s2_neg_r ? -$signed({2'b00, s2_q_r}) : $signed({2'b00, s2_q_r});
    base = (cfg.mode == MODE_BRIGHT) ? $signed({5'd0, s2_pix_r}) : $signed(MID_LEVEL);
    sum  = base + q_signed;
    if (sum < 0) begin
      clamped = 8'd0;
    end else if (sum > $signed({5'd0, LEVEL_MAX})) begin
      clamped = LEVEL_MAX;
    end else begin
      clamped = sum[7:0];
    end
    if (force_max) begin
      pix_out_nxt = LEVEL_MAX;
    end else begin
      case (cfg.mode)
        MODE_PASS:                    pix_out_nxt = s2_pix_r;
        MODE_BRIGHT, MODE_CONTRAST:   pix_out_nxt = clamped;
        MODE_GAMMA:                   pix_out_nxt = s2_gam_r;
        default:                      pix_out_nxt = s2_pix_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      pix_out_r <= pix_out_nxt;
    end
  end

  assign pix_out = pix_out_r;

endmodule
`default_nettype wire

// ===== hdl/pixel_tone_adjust.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_tone_adjust: brightness, contrast and gamma on 32-bit pixels
// Four identical lanes handle red, green, blue and alpha side by side; the
// output word merges the lane results.
//
//   Channel   Direction   Payload
//   in_*      slave       tuser: opcode; tdata: r, g, b, a, index, value
//   out_*     master      tdata: r, g, b, a
//   cfg_*     write only  index 0..3, 11-bit data
//
// One item per clock while the output does not stall; a pixel's result
// passes the product, reciprocal-multiply and clamp stages in turn before
// it is valid and can transfer out.
// Gamma table writes produce no output.
// Reset is synchronous; it empties the pipeline and loads register defaults.
// The gamma table holds no defined contents after reset.
// Output stalls back up stage by stage; in_tready drops only when all three
// stages hold pixels and out_tready is low.
// ----------------------------------------------------------------------------
module pixel_tone_adjust (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // red, green, blue, alpha, index, value
  input  wire logic        in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // red, green, blue, alpha
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata
);
  import pta_pkg::*;

  localparam int NUM_LANES = 4;

  pta_mode_t          mode_r;
  logic signed [7:0]  bright_r;
  logic signed [10:0] contrast_r;
  logic               has_alpha_r;

  pta_cfg_t cfg;
  pta_adv_t adv;
  logic     is_pixel;
  logic     tbl_wr_en;
  logic [NUM_LANES-1:0] force_max;
  logic [7:0] lane_in  [NUM_LANES];
  logic [7:0] lane_out [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PASS;
      bright_r    <= 8'sd0;
      contrast_r  <= 11'sd100;
      has_alpha_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (pta_reg_t'(cfg_index))
        REG_MODE:      mode_r      <= pta_mode_t'(cfg_wdata[1:0]);
        REG_BRIGHT:    bright_r    <= $signed(cfg_wdata[7:0]);
        REG_CONTRAST:  contrast_r  <= $signed(cfg_wdata);
        REG_HAS_ALPHA: has_alpha_r <= cfg_wdata[0];
        default:       mode_r      <= mode_r;
      endcase
    end
  end

  assign cfg = '{mode: mode_r, bright: bright_r, contrast: contrast_r};

  assign is_pixel  = (pta_op_t'(in_tuser) == OP_PIXEL);
  assign tbl_wr_en = in_tvalid && in_tready && (pta_op_t'(in_tuser) == OP_TABLE_WR);

  // Without alpha the alpha lane is pinned to full scale, except in pass-through.
  assign force_max = {(mode_r != MODE_PASS) && !has_alpha_r, 3'b000};

  pta_flow u_flow (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .is_pixel   (is_pixel),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .adv        (adv)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    assign lane_in[i] = in_tdata[8*i +: 8];

    pta_lane u_lane (
      .clk         (clk),
      .cfg         (cfg),
      .adv         (adv),
      .force_max   (force_max[i]),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (in_tdata[39:32]),
      .tbl_wr_data (in_tdata[47:40]),
      .pix_in      (lane_in[i]),
      .pix_out     (lane_out[i])
    );

    assign out_tdata[8*i +: 8] = lane_out[i];
  end

endmodule
`default_nettype wire

// ===== hdl/pta_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pta_checker: port-level checks of the pixel tone adjuster
// Watches the stream and configuration ports; bound to the top level below.
// ----------------------------------------------------------------------------
module pta_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        cfg_wr_en
);
  import pta_pkg::*;

  logic pix_xfer;
  assign pix_xfer = in_tvalid && in_tready && (pta_op_t'(in_tuser) == OP_PIXEL);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
      !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // With the output draining, a transferred pixel's result shows up as valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
      pix_xfer ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("pixel result missing");

  // Registers change only while no result is waiting.
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
      cfg_wr_en |-> !out_tvalid)
    else $error("configuration written with a result pending");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind pixel_tone_adjust pta_checker u_pta_checker (.*);
`default_nettype wire

// ===== tb/sv/pixel_tone_adjust_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_tone_adjust_tb: self-checking bench for the pixel tone adjuster
// Streams pixels and gamma table writes through the block under every mode,
// predicts each adjusted pixel from a mirror of the registers and the table,
// and compares every output transfer field by field, with random gaps on the
// input and random stalls on the output.
// ----------------------------------------------------------------------------
module pixel_tone_adjust_tb;
  import pta_pkg::*;

  localparam int FULL_SCALE  = 255;
  localparam int PCT_DIV     = 100;
  localparam int MID_GREY    = 127;
  localparam int MAX_WAIT    = 13;
  localparam int SETTLE      = 6;
  localparam int CYCLE_LIMIT = 200000;

  // Packed so that red sits in the lowest byte, as on the stream buses.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_wdata;

  // Mirror of the block's registers and gamma table.
  pta_mode_t          cur_mode;
  logic signed [7:0]  cur_bright;
  logic signed [10:0] cur_contrast;
  logic               cur_alpha;
  logic [7:0]         gamma_lut [256];
  bit   [255:0]       lut_written;
  logic [7:0]         written_list[$];

  pixel_t expected_pixels[$];
  bit     no_idle;
  int     err_count;
  int     cycle_count;

  pixel_tone_adjust u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] tone_level(logic [7:0] v);
    int s;
    int t;
    s = int'(v);
    case (cur_mode)
      MODE_BRIGHT:   t = s + int'(cur_bright) * FULL_SCALE / PCT_DIV;
      MODE_CONTRAST: t = (s - MID_GREY) * int'(cur_contrast) / PCT_DIV + MID_GREY;
      MODE_GAMMA:    return gamma_lut[v];
      default:       return v;
    endcase
    if (t < 0) return 8'd0;
    if (t > FULL_SCALE) return 8'hFF;
    return t[7:0];
  endfunction

  function automatic pixel_t predict_pixel(pixel_t p);
    pixel_t q;
    if (cur_mode == MODE_PASS) return p;
    q.red   = tone_level(p.red);
    q.green = tone_level(p.green);
    q.blue  = tone_level(p.blue);
    q.alpha = cur_alpha ? tone_level(p.alpha) : 8'hFF;
    return q;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    pixel_t want;
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected output pixel %08h", got));
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", got.red, want.red);
        check_field("green", got.green, want.green);
        check_field("blue", got.blue, want.blue);
        check_field("alpha", got.alpha, want.alpha);
      end
    end
  end

  // Output side: a fresh random stall, which may be empty, before every result transfer.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with in_tvalid still high, so back-to-back items follow without a gap.
  task automatic send_item(pta_op_t op, pixel_t px, logic [7:0] idx, logic [7:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {val, idx, px};
    do @(posedge clk); while (!in_tready);
    if (op == OP_TABLE_WR) begin
      gamma_lut[idx] = val;
      if (!lut_written[idx]) begin
        lut_written[idx] = 1'b1;
        written_list.push_back(idx);
      end
    end else begin
      expected_pixels.push_back(predict_pixel(px));
    end
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    send_item(OP_PIXEL, {a, b, g, r}, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_table_write(logic [7:0] idx, logic [7:0] val);
    send_item(OP_TABLE_WR, pixel_t'($urandom), idx, val);
  endtask

  // Table writes leave nothing to wait for, so a settling wait follows the last
  // result before the block counts as idle.
  task automatic drain_pipe();
    in_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(pta_reg_t which, logic [10:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = which;
    cfg_wdata = data;
    case (which)
      REG_MODE:      cur_mode     = pta_mode_t'(data[1:0]);
      REG_BRIGHT:    cur_bright   = data[7:0];
      REG_CONTRAST:  cur_contrast = data;
      REG_HAS_ALPHA: cur_alpha    = data[0];
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // In gamma mode only entries already loaded may be looked up.
  function automatic logic [7:0] pick_level();
    if (cur_mode == MODE_GAMMA)
      return written_list[$urandom_range(0, written_list.size() - 1)];
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [10:0] pick_bright();
    int v;
    case ($urandom_range(0, 3))
      0:       v = -100;
      1:       v = 100;
      2:       v = int'($urandom_range(0, 200)) - 100;
      default: v = int'($urandom_range(0, 2047));
    endcase
    return 11'(v);
  endfunction

  function automatic logic [10:0] pick_contrast();
    int v;
    case ($urandom_range(0, 4))
      0:       v = -1000;
      1:       v = 1000;
      2:       v = int'($urandom_range(0, 2000)) - 1000;
      3:       v = int'($urandom_range(50, 150));
      default: v = int'($urandom_range(0, 2047));
    endcase
    return 11'(v);
  endfunction

  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3);
    send_table_write(8'h80, 8'h11);
    drain_pipe();
    // Pass-through keeps alpha even with the alpha channel switched off.
    cfg_write(REG_HAS_ALPHA, 11'd0);
    send_pixel(8'h01, 8'h02, 8'h03, 8'h40);
    drain_pipe();
  endtask

  task automatic test_brightness();
    cfg_write(REG_MODE, 11'(MODE_BRIGHT));
    cfg_write(REG_HAS_ALPHA, 11'd1);
    cfg_write(REG_BRIGHT, 11'(100));
    send_pixel(8'h00, 8'h80, 8'hFF, 8'h01);
    drain_pipe();
    cfg_write(REG_BRIGHT, 11'(-100));
    send_pixel(8'h00, 8'h80, 8'hFF, 8'hFE);
    drain_pipe();
    cfg_write(REG_HAS_ALPHA, 11'd0);
    cfg_write(REG_BRIGHT, 11'(127));
    send_pixel(8'h0A, 8'hC8, 8'hFF, 8'h00);
    drain_pipe();
    cfg_write(REG_BRIGHT, 11'(-128));
    send_pixel(8'hFF, 8'hF0, 8'h40, 8'h33);
    drain_pipe();
    // A small negative step checks truncation toward zero.
    cfg_write(REG_HAS_ALPHA, 11'd1);
    cfg_write(REG_BRIGHT, 11'(-1));
    send_pixel(8'h00, 8'h01, 8'h02, 8'h03);
    drain_pipe();
  endtask

  task automatic test_contrast();
    cfg_write(REG_MODE, 11'(MODE_CONTRAST));
    cfg_write(REG_CONTRAST, 11'(1000));
    send_pixel(8'h00, 8'h7F, 8'h80, 8'hFF);
    drain_pipe();
    cfg_write(REG_CONTRAST, 11'(-1000));
    send_pixel(8'h00, 8'h7F, 8'h80, 8'hFF);
    drain_pipe();
    cfg_write(REG_CONTRAST, 11'(1023));
    send_pixel(8'h7E, 8'h81, 8'h00, 8'hFF);
    drain_pipe();
    cfg_write(REG_CONTRAST, 11'(-1024));
    cfg_write(REG_HAS_ALPHA, 11'd0);
    send_pixel(8'h7E, 8'h81, 8'h00, 8'hFF);
    drain_pipe();
    cfg_write(REG_CONTRAST, 11'(0));
    send_pixel(8'h00, 8'h55, 8'hFF, 8'h10);
    drain_pipe();
    cfg_write(REG_HAS_ALPHA, 11'd1);
    cfg_write(REG_CONTRAST, 11'(101));
    send_pixel(8'h00, 8'h3C, 8'hC8, 8'hFF);
    drain_pipe();
  endtask

  task automatic test_gamma_table();
    send_table_write(8'h00, 8'hFF);
    send_table_write(8'hFF, 8'h00);
    send_table_write(8'h7F, 8'h12);
    send_table_write(8'h80, 8'hED);
    drain_pipe();
    cfg_write(REG_MODE, 11'(MODE_GAMMA));
    send_pixel(8'h00, 8'hFF, 8'h7F, 8'h80);
    // A rewrite must be seen by the pixel right behind it.
    no_idle = 1'b1;
    send_table_write(8'h00, 8'h42);
    send_pixel(8'h00, 8'h00, 8'hFF, 8'h00);
    no_idle = 1'b0;
    drain_pipe();
    cfg_write(REG_HAS_ALPHA, 11'd0);
    send_pixel(8'h80, 8'h7F, 8'h00, 8'hFF);
    drain_pipe();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 10; phase++) begin
      drain_pipe();
      cfg_write(REG_MODE, {9'($urandom), 2'(phase % 4)});
      cfg_write(REG_BRIGHT, pick_bright());
      cfg_write(REG_CONTRAST, pick_contrast());
      cfg_write(REG_HAS_ALPHA, 11'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (38) begin
        if ($urandom_range(0, 4) == 0)
          send_table_write(8'($urandom), 8'($urandom));
        else
          send_pixel(pick_level(), pick_level(), pick_level(), pick_level());
      end
    end
    no_idle = 1'b0;
    drain_pipe();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    cycle_count  = 0;
    err_count    = 0;
    no_idle      = 1'b0;
    lut_written  = '0;
    cur_mode     = MODE_PASS;
    cur_bright   = 8'sd0;
    cur_contrast = 11'sd100;
    cur_alpha    = 1'b1;
    for (int i = 0; i < 256; i++) gamma_lut[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_brightness();
    test_contrast();
    test_gamma_table();
    test_random_stream();

    repeat (10) @(negedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
